### sv/radix_digit_add_multiply_defines.svh
// Assertion macros shared by the radix digit adder and multiplier.
// Defining SYNTH turns every macro into an empty body.
`ifndef RADIX_DIGIT_ADD_MULTIPLY_DEFINES_SVH
`define RADIX_DIGIT_ADD_MULTIPLY_DEFINES_SVH
`ifndef SYNTH
`define RDAM_ASSERT(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("rdam: assertion failed");
`define RDAM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rdam: implication failed");
`define RDAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rdam: next-cycle check failed");
`else
`define RDAM_ASSERT(label, clk, rst_n, expr)
`define RDAM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RDAM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/rdam_pkg.sv
// Types, codes and the digit divide helper for the radix digit adder and multiplier.
// No dependencies.
package rdam_pkg;

	localparam logic       OP_ADD       = 1'b0;
	localparam logic       OP_MUL       = 1'b1;
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_TOO_LONG = 2'd1;
	localparam logic [1:0] ERR_DIGIT    = 2'd2;
	localparam logic [4:0] RADIX_MIN    = 5'd2;
	localparam logic [4:0] RADIX_MAX    = 5'd16;
	localparam logic [4:0] RADIX_RESET  = 5'd10;

	typedef struct packed {
		logic       opcode;
		logic [3:0] digit_a;
		logic [3:0] digit_b;
		logic       final_digit;
	} operand_t;

	typedef struct packed {
		logic [3:0] result_digit;
		logic       last_of_run;
		logic [1:0] error_code;
	} result_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic use_acc;
	} mac_ctrl_t;

	typedef struct packed {
		logic [3:0] quot;
		logic [3:0] rem;
	} divmod_t;

	// Restoring division of a column total by the radix. The total is always
	// below sixteen times the radix, so four quotient bits suffice.
	function automatic divmod_t digit_divmod(input logic [7:0] t, input logic [4:0] r);
		logic [8:0] part;
		logic [8:0] d;
		divmod_t    res;
		part = {1'b0, t};
		res  = '0;
		for (int k = 3; k >= 0; k--) begin
			d = {4'b0, r} << k;
			if (part >= d) begin
				part       = part - d;
				res.quot[k] = 1'b1;
			end
		end
		res.rem = part[3:0];
		return res;
	endfunction

endpackage

### sv/rdam_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module rdam_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### sv/rdam_mac.sv
// Digit add or multiply-accumulate stage followed by the divide by the radix.
// Depends on rdam_pkg.
module rdam_mac
	import rdam_pkg::*;
(
	input  logic       clk,
	input  mac_ctrl_t  ctrl,
	input  logic [3:0] a,
	input  logic [3:0] b,
	input  logic [3:0] acc,
	input  logic [3:0] carry,
	input  logic [4:0] radix,
	output logic [3:0] quot,
	output logic [3:0] rem
);

	logic [7:0] term;
	logic [7:0] acc_ext;
	logic [7:0] t_s1;
	divmod_t    dm;

	assign term    = ctrl.mul ? ({4'b0, a} * {4'b0, b}) : ({4'b0, a} + {4'b0, b});
	assign acc_ext = ctrl.use_acc ? {4'b0, acc} : 8'd0;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			t_s1 <= acc_ext + term + {4'b0, carry};
		end
	end

	assign dm   = digit_divmod(t_s1, radix);
	assign quot = dm.quot;
	assign rem  = dm.rem;

endmodule

### sv/radix_digit_add_multiply.sv
// Multi-digit adder and schoolbook multiplier in a radix from 2 to 16. Digit pairs load at one
// word per cycle, least significant first; the word with final_digit set starts the run and
// holds off further operand words until the last result word is taken. Every digit step is a
// read, add or multiply-accumulate, and divide-and-write pass over the result memory: an add
// makes n passes and a multiply n*n for n loaded digits, each row ending in a carry write.
// Emitting reads and checks every result digit; suppressed leading zeros are read, not sent.
// An error gives one word, valid in the cycle after the final operand word is taken.
`include "radix_digit_add_multiply_defines.svh"
module radix_digit_add_multiply
	import rdam_pkg::*;
#(
	parameter int MAX_DIGITS = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic [4:0] cfg_data,
	input  logic     operand_valid,
	output logic     operand_stall,
	input  operand_t operand,
	output logic     result_valid,
	input  logic     result_stall,
	output result_t  result
);

	localparam int IDX_W = $clog2(MAX_DIGITS);
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int RES_DEPTH = 2 * MAX_DIGITS;
	localparam int RW = $clog2(RES_DEPTH);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);

	typedef enum logic [2:0] {
		S_LOAD,
		S_RD,
		S_MAC,
		S_DIV,
		S_CARRY,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_EMIT
	} state_t;

	state_t           state_q;
	logic [4:0]       radix_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] n_q;
	logic [1:0]       err_q;
	logic [3:0]       dmax_q;
	logic             op_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [3:0]       carry_q;
	logic [RW-1:0]    p_q;
	logic             lead_q;
	result_t          out_q;
	logic             out_valid_q;

	logic [4:0]       r_eff;
	logic             accept;
	logic             store;
	logic             item_bad;
	logic [3:0]       dmax_ab;
	logic [3:0]       dmax_item;
	logic [1:0]       err_item;
	logic [1:0]       err_final;
	logic [CNT_W-1:0] count_next;
	logic [IDX_W-1:0] n_m1;
	logic [RW-1:0]    ij_addr;
	logic [RW-1:0]    top_addr;

	logic [3:0]       a_rdata;
	logic [3:0]       b_rdata;
	logic [3:0]       r_rdata;
	logic             r_we;
	logic [RW-1:0]    r_waddr;
	logic [3:0]       r_wdata;
	logic [RW-1:0]    r_raddr;
	mac_ctrl_t        mac_ctrl;
	logic [3:0]       quot;
	logic [3:0]       rem;

	assign r_eff = (radix_q < RADIX_MIN) ? RADIX_MIN :
		(radix_q > RADIX_MAX) ? RADIX_MAX : radix_q;

	assign cfg_ready     = 1'b1;
	assign operand_stall = (state_q != S_LOAD);
	assign accept        = operand_valid && !operand_stall;
	assign result_valid  = out_valid_q;
	assign result        = out_q;

	assign store      = (count_q < MAX_CNT);
	assign item_bad   = ({1'b0, operand.digit_a} >= r_eff) || ({1'b0, operand.digit_b} >= r_eff);
	assign dmax_ab    = (operand.digit_a > operand.digit_b) ? operand.digit_a : operand.digit_b;
	assign dmax_item  = (store && dmax_ab > dmax_q) ? dmax_ab : dmax_q;
	assign err_item   = (err_q != ERR_NONE) ? err_q :
		!store ? ERR_TOO_LONG : item_bad ? ERR_DIGIT : ERR_NONE;
	assign err_final  = (err_item != ERR_NONE) ? err_item :
		({1'b0, dmax_item} >= r_eff) ? ERR_DIGIT : ERR_NONE;
	assign count_next = store ? count_q + CNT_W'(1) : count_q;

	assign n_m1     = IDX_W'(n_q - CNT_W'(1));
	assign ij_addr  = RW'(i_q) + RW'(j_q);
	assign top_addr = op_q ? (RW'(n_q) << 1) - RW'(1) : RW'(n_q);

	assign r_we    = (state_q == S_DIV) || (state_q == S_CARRY);
	assign r_waddr = (state_q == S_CARRY) ? RW'(j_q) + RW'(n_q) : ij_addr;
	assign r_wdata = (state_q == S_CARRY) ? carry_q : rem;
	assign r_raddr = (state_q == S_SCAN_RD) ? p_q : ij_addr;

	assign mac_ctrl.load    = (state_q == S_MAC);
	assign mac_ctrl.mul     = op_q;
	assign mac_ctrl.use_acc = op_q && (j_q != '0);

	rdam_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS)) u_mem_a (
		.clk   (clk),
		.we    (accept && store),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (operand.digit_a),
		.raddr (i_q),
		.rdata (a_rdata)
	);

	rdam_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS)) u_mem_b (
		.clk   (clk),
		.we    (accept && store),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (operand.digit_b),
		.raddr (op_q ? j_q : i_q),
		.rdata (b_rdata)
	);

	rdam_ram #(.WIDTH(4), .DEPTH(RES_DEPTH)) u_mem_r (
		.clk   (clk),
		.we    (r_we),
		.waddr (r_waddr),
		.wdata (r_wdata),
		.raddr (r_raddr),
		.rdata (r_rdata)
	);

	rdam_mac u_mac (
		.clk   (clk),
		.ctrl  (mac_ctrl),
		.a     (a_rdata),
		.b     (b_rdata),
		.acc   (r_rdata),
		.carry (carry_q),
		.radix (r_eff),
		.quot  (quot),
		.rem   (rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			radix_q     <= RADIX_RESET;
			count_q     <= '0;
			n_q         <= '0;
			err_q       <= ERR_NONE;
			dmax_q      <= '0;
			op_q        <= OP_ADD;
			i_q         <= '0;
			j_q         <= '0;
			carry_q     <= '0;
			p_q         <= '0;
			lead_q      <= 1'b0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				radix_q <= cfg_data;
			end
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (!operand.final_digit) begin
							count_q <= count_next;
							err_q   <= err_item;
							dmax_q  <= dmax_item;
						end else begin
							count_q <= '0;
							err_q   <= ERR_NONE;
							dmax_q  <= '0;
							n_q     <= count_next;
							if (err_final != ERR_NONE) begin
								out_q.result_digit <= 4'd0;
								out_q.last_of_run  <= 1'b1;
								out_q.error_code   <= err_final;
								out_valid_q        <= 1'b1;
								state_q            <= S_EMIT;
							end else begin
								op_q    <= operand.opcode;
								i_q     <= '0;
								j_q     <= '0;
								carry_q <= '0;
								state_q <= S_RD;
							end
						end
					end
				end
				S_RD: begin
					state_q <= S_MAC;
				end
				S_MAC: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					carry_q <= quot;
					if (i_q == n_m1) begin
						state_q <= S_CARRY;
					end else begin
						i_q     <= i_q + IDX_W'(1);
						state_q <= S_RD;
					end
				end
				S_CARRY: begin
					carry_q <= '0;
					i_q     <= '0;
					if (op_q == OP_ADD || j_q == n_m1) begin
						p_q     <= top_addr;
						lead_q  <= 1'b1;
						state_q <= S_SCAN_RD;
					end else begin
						j_q     <= j_q + IDX_W'(1);
						state_q <= S_RD;
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CHK;
				end
				S_SCAN_CHK: begin
					if (lead_q && r_rdata == 4'd0 && p_q != '0) begin
						p_q     <= p_q - RW'(1);
						state_q <= S_SCAN_RD;
					end else begin
						out_q.result_digit <= r_rdata;
						out_q.last_of_run  <= (p_q == '0);
						out_q.error_code   <= ERR_NONE;
						out_valid_q        <= 1'b1;
						lead_q             <= 1'b0;
						state_q            <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!result_stall) begin
						out_valid_q <= 1'b0;
						if (out_q.last_of_run) begin
							state_q <= S_LOAD;
						end else begin
							p_q     <= p_q - RW'(1);
							state_q <= S_SCAN_RD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	`RDAM_ASSERT(a_no_load_while_out, clk, arst_n, !(out_valid_q && state_q == S_LOAD))
	`RDAM_ASSERT(a_count_bound, clk, arst_n, count_q <= MAX_CNT)
	`RDAM_ASSERT_IMPL(a_err_word, clk, arst_n, out_valid_q && out_q.error_code != ERR_NONE, out_q.result_digit == 4'd0 && out_q.last_of_run)
	`RDAM_ASSERT_NEXT(a_back_to_load, clk, arst_n, out_valid_q && !result_stall && out_q.last_of_run, state_q == S_LOAD)
	`RDAM_ASSERT_IMPL(a_col_bound, clk, arst_n, state_q == S_DIV, i_q <= n_m1 && j_q <= n_m1)

endmodule

### tb/radix_digit_add_multiply_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for radix_digit_add_multiply: a directed table, then random digit runs.
// Expected result words come from the table or an in-bench sum/product predictor. Depends on rdam_pkg.
module radix_digit_add_multiply_tb;
	import rdam_pkg::*;

	localparam int MAX_DIGITS = 32;
	localparam int SETTLE = 20;
	localparam int RANDOM_ITEMS = 460;

	typedef struct packed {
		logic       is_cfg;
		logic [4:0] radix_value;
		operand_t   word;
		logic [1:0] n_typed;
		result_t    want0;
		result_t    want1;
	} drow_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [4:0] cfg_data = '0;
	logic       operand_valid = 1'b0;
	logic       operand_stall;
	operand_t   operand = '0;
	logic       result_valid;
	logic       result_stall = 1'b1;
	result_t    result;

	logic [3:0] pred_a [MAX_DIGITS];
	logic [3:0] pred_b [MAX_DIGITS];
	int         pred_count;
	logic [1:0] pred_err;
	logic [4:0] pred_radix;

	result_t expected_digits [$];
	int      errors = 0;
	int      items_sent = 0;
	bit      tx_quiet = 1'b0;
	bit      rx_quiet = 1'b0;
	int      rx_cycles = 0;
	int      rx_wait = 0;
	int      hold_end = 0;

	radix_digit_add_multiply #(.MAX_DIGITS(MAX_DIGITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.operand_valid(operand_valid),
		.operand_stall(operand_stall),
		.operand(operand),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #2 clk = ~clk;

	function automatic result_t rw(int d, logic last, logic [1:0] err);
		result_t x;
		x.result_digit = 4'(d);
		x.last_of_run = last;
		x.error_code = err;
		return x;
	endfunction

	function automatic drow_t item_row(logic op, int a, int b, logic fin, int nt,
			result_t e0, result_t e1);
		drow_t x;
		x = '0;
		x.word.opcode = op;
		x.word.digit_a = 4'(a);
		x.word.digit_b = 4'(b);
		x.word.final_digit = fin;
		x.n_typed = 2'(nt);
		x.want0 = e0;
		x.want1 = e1;
		return x;
	endfunction

	function automatic drow_t cfg_row(int v);
		drow_t x;
		x = '0;
		x.is_cfg = 1'b1;
		x.radix_value = 5'(v);
		return x;
	endfunction

	localparam result_t NO_WORD = '0;

	localparam drow_t DIRECTED [29] = '{
		item_row(OP_ADD, 0, 0, 1, 1, rw(0, 1, ERR_NONE), NO_WORD),
		item_row(OP_MUL, 9, 9, 1, 2, rw(8, 0, ERR_NONE), rw(1, 1, ERR_NONE)),
		item_row(OP_ADD, 9, 9, 0, 0, NO_WORD, NO_WORD),
		item_row(OP_ADD, 9, 9, 1, 0, NO_WORD, NO_WORD),
		item_row(OP_MUL, 2, 3, 0, 0, NO_WORD, NO_WORD),
		item_row(OP_MUL, 1, 0, 1, 0, NO_WORD, NO_WORD),
		item_row(OP_MUL, 5, 0, 0, 0, NO_WORD, NO_WORD),
		item_row(OP_MUL, 0, 0, 1, 1, rw(0, 1, ERR_NONE), NO_WORD),
		item_row(OP_ADD, 15, 0, 1, 1, rw(0, 1, ERR_DIGIT), NO_WORD),
		item_row(OP_ADD, 3, 10, 0, 0, NO_WORD, NO_WORD),
		item_row(OP_ADD, 0, 0, 1, 1, rw(0, 1, ERR_DIGIT), NO_WORD),
		cfg_row(16),
		item_row(OP_MUL, 15, 15, 1, 2, rw(14, 0, ERR_NONE), rw(1, 1, ERR_NONE)),
		item_row(OP_ADD, 15, 15, 0, 0, NO_WORD, NO_WORD),
		item_row(OP_ADD, 15, 15, 1, 0, NO_WORD, NO_WORD),
		cfg_row(2),
		item_row(OP_ADD, 1, 1, 1, 2, rw(1, 0, ERR_NONE), rw(0, 1, ERR_NONE)),
		item_row(OP_MUL, 2, 1, 1, 1, rw(0, 1, ERR_DIGIT), NO_WORD),
		cfg_row(0),
		item_row(OP_MUL, 1, 1, 1, 1, rw(1, 1, ERR_NONE), NO_WORD),
		item_row(OP_ADD, 1, 1, 1, 2, rw(1, 0, ERR_NONE), rw(0, 1, ERR_NONE)),
		cfg_row(31),
		item_row(OP_ADD, 15, 15, 1, 2, rw(1, 0, ERR_NONE), rw(14, 1, ERR_NONE)),
		cfg_row(1),
		item_row(OP_ADD, 1, 0, 0, 0, NO_WORD, NO_WORD),
		item_row(OP_ADD, 1, 1, 1, 0, NO_WORD, NO_WORD),
		cfg_row(17),
		item_row(OP_MUL, 15, 15, 1, 2, rw(14, 0, ERR_NONE), rw(1, 1, ERR_NONE)),
		cfg_row(10)
	};

	function automatic int eff_radix();
		if (pred_radix < RADIX_MIN)
			return int'(RADIX_MIN);
		if (pred_radix > RADIX_MAX)
			return int'(RADIX_MAX);
		return int'(pred_radix);
	endfunction

	function automatic int draw_idle(bit quiet);
		if (quiet || $urandom_range(0, 3) == 0)
			return 0;
		return int'($urandom_range(0, 16));
	endfunction

	// Loads one digit pair; on the final word, works out the sum or product digits or the error word.
	function automatic void predict_digit_pair(input operand_t w, ref result_t outs[$]);
		int r;
		int n;
		int len;
		int top;
		int t;
		int carry;
		int acc [2*MAX_DIGITS];
		r = eff_radix();
		outs.delete();
		if (pred_count >= MAX_DIGITS) begin
			if (pred_err == ERR_NONE)
				pred_err = ERR_TOO_LONG;
		end else begin
			pred_a[pred_count] = w.digit_a;
			pred_b[pred_count] = w.digit_b;
			if ((w.digit_a >= r || w.digit_b >= r) && pred_err == ERR_NONE)
				pred_err = ERR_DIGIT;
			pred_count++;
		end
		if (!w.final_digit)
			return;
		n = pred_count;
		if (pred_err == ERR_NONE) begin
			for (int i = 0; i < n; i++)
				if (pred_a[i] >= r || pred_b[i] >= r)
					pred_err = ERR_DIGIT;
		end
		if (pred_err != ERR_NONE) begin
			outs.push_back(rw(0, 1'b1, pred_err));
			pred_count = 0;
			pred_err = ERR_NONE;
			return;
		end
		foreach (acc[i])
			acc[i] = 0;
		if (w.opcode == OP_MUL) begin
			for (int j = 0; j < n; j++) begin
				carry = 0;
				for (int i = 0; i < n; i++) begin
					t = acc[i+j] + int'(pred_a[i]) * int'(pred_b[j]) + carry;
					acc[i+j] = t % r;
					carry = t / r;
				end
				acc[j+n] = carry;
			end
			len = 2 * n;
		end else begin
			carry = 0;
			for (int i = 0; i < n; i++) begin
				t = int'(pred_a[i]) + int'(pred_b[i]) + carry;
				acc[i] = t % r;
				carry = t / r;
			end
			acc[n] = carry;
			len = n + 1;
		end
		top = 0;
		for (int i = len - 1; i >= 0; i--) begin
			if (acc[i] != 0) begin
				top = i;
				break;
			end
		end
		for (int i = top; i >= 0; i--)
			outs.push_back(rw(acc[i], i == 0, ERR_NONE));
		pred_count = 0;
		pred_err = ERR_NONE;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		errors++;
	endtask

	task automatic send_word(input operand_t w, input logic [1:0] n_typed,
			input result_t t0, input result_t t1);
		int gap;
		result_t outs [$];
		gap = draw_idle(tx_quiet);
		if (gap != 0) begin
			operand_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		operand_valid <= 1'b1;
		operand <= w;
		do @(posedge clk); while (!(operand_valid && !operand_stall));
		predict_digit_pair(w, outs);
		if (n_typed != 0) begin
			outs.delete();
			outs.push_back(t0);
			if (n_typed == 2)
				outs.push_back(t1);
		end
		foreach (outs[i])
			expected_digits.push_back(outs[i]);
		items_sent++;
	endtask

	task automatic wait_idle();
		operand_valid <= 1'b0;
		do @(posedge clk); while (expected_digits.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_radix(input logic [4:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		pred_radix = v;
	endtask

	task automatic send_run(input int n, input logic op, input int bad_pos, input bit top_digits);
		int r;
		operand_t w;
		r = eff_radix();
		for (int k = 0; k < n; k++) begin
			w.digit_a = top_digits ? 4'(r - 1) : 4'($urandom_range(0, r - 1));
			w.digit_b = top_digits ? 4'(r - 1) : 4'($urandom_range(0, r - 1));
			if (k == bad_pos) begin
				if ($urandom_range(0, 1) == 1)
					w.digit_a = 4'($urandom_range(r, 15));
				else
					w.digit_b = 4'($urandom_range(r, 15));
			end
			w.final_digit = (k == n - 1);
			w.opcode = w.final_digit ? op : 1'($urandom_range(0, 1));
			send_word(w, 2'd0, NO_WORD, NO_WORD);
		end
	endtask

	always @(posedge clk) begin
		rx_cycles++;
		if (result_valid && !result_stall)
			rx_wait = draw_idle(rx_quiet);
		if (rx_cycles < hold_end) begin
			result_stall <= 1'b1;
		end else if (rx_wait != 0) begin
			rx_wait--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_digits.size() == 0) begin
				flag_mismatch($sformatf("unexpected result word %h", result));
			end else begin
				want = expected_digits.pop_front();
				if (result.result_digit !== want.result_digit)
					flag_mismatch($sformatf("result_digit %0d, expected %0d",
						result.result_digit, want.result_digit));
				if (result.last_of_run !== want.last_of_run)
					flag_mismatch($sformatf("last_of_run %0b, expected %0b",
						result.last_of_run, want.last_of_run));
				if (result.error_code !== want.error_code)
					flag_mismatch($sformatf("error_code %0d, expected %0d",
						result.error_code, want.error_code));
			end
		end
	end

	initial begin
		#4_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int phase;
		int start;
		int n;
		int r;
		logic [4:0] v;
		pred_count = 0;
		pred_err = ERR_NONE;
		pred_radix = RADIX_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].is_cfg) begin
				wait_idle();
				write_radix(DIRECTED[i].radix_value);
			end else begin
				send_word(DIRECTED[i].word, DIRECTED[i].n_typed,
					DIRECTED[i].want0, DIRECTED[i].want1);
			end
		end

		start = items_sent;
		phase = 0;
		while (items_sent - start < RANDOM_ITEMS) begin
			case (phase % 6)
				0: v = RADIX_MAX;
				1: v = RADIX_MIN;
				2: v = 5'($urandom_range(3, 15));
				3: v = 5'd31;
				4: v = 5'($urandom_range(0, 1));
				default: v = 5'($urandom_range(0, 31));
			endcase
			wait_idle();
			write_radix(v);
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			r = eff_radix();
			if (phase == 0)
				send_run(MAX_DIGITS, OP_MUL, -1, 1'b1);
			if (phase == 1) begin
				send_run(MAX_DIGITS + 1, OP_ADD, -1, 1'b0);
				hold_end = rx_cycles + 300;
				tx_quiet = 1'b1;
				repeat (4) send_run($urandom_range(1, 4), 1'($urandom_range(0, 1)), -1, 1'b0);
				tx_quiet = 1'b0;
			end
			if (phase == 2)
				send_run(MAX_DIGITS + 2, OP_MUL, 3, 1'b0);
			v = 5'(items_sent);
			for (int k = items_sent; items_sent - k < 70; ) begin
				n = ($urandom_range(0, 14) == 0) ? $urandom_range(7, MAX_DIGITS + 2)
					: $urandom_range(1, 6);
				send_run(n, 1'($urandom_range(0, 1)),
					(r < 16 && $urandom_range(0, 7) == 0) ? $urandom_range(0, n - 1) : -1,
					$urandom_range(0, 5) == 0);
			end
			phase++;
		end

		wait_idle();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
